FILE: rtl/core/chtc_pkg.sv
// shared types, codes and helper functions for the chained crc32 hash table
// no dependencies

package chtc_pkg;

  localparam int KEY_W     = 64;
  localparam int IDX_IN_W  = 12;
  localparam int STAT_W    = 3;
  localparam int KB_W      = 4;
  localparam int BKT_FLD_W = 16;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [KB_W-1:0] KB_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 3'd0,
    ST_NEW   = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_BADID = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [KEY_W-1:0]     key;
    logic [IDX_IN_W-1:0]  idx;
    logic                 reclaim;
    logic [BKT_FLD_W-1:0] bucket;
  } q_item_t;

  typedef enum logic {
    FR_IDLE,
    FR_HASH
  } front_state_t;

  typedef enum logic [2:0] {
    HS_IDLE,
    HS_CRC,
    HS_MUL,
    HS_SUB,
    HS_FIX
  } hash_state_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_HEAD_RD,
    BK_HEAD_CHK,
    BK_WALK,
    BK_MISS,
    BK_ID_RD,
    BK_ID_CHK,
    BK_REM_HASH,
    BK_UNL_HEAD,
    BK_UNL_HEADFIX,
    BK_UNL_WALK,
    BK_UNL_LINKFIX,
    BK_UNL_LINKNIL,
    BK_REM_FIN
  } back_state_t;

  // zero acts as one byte, anything above eight as eight
  function automatic logic [KB_W-1:0] eff_len(logic [KB_W-1:0] kb);
    logic [KB_W-1:0] n;
    if (kb == '0) n = 4'd1;
    else if (kb > 4'd8) n = 4'd8;
    else n = kb;
    return n;
  endfunction

  function automatic logic [KEY_W-1:0] key_mask(logic [KEY_W-1:0] k, logic [KB_W-1:0] n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (KB_W'(i) < n) m[8*i +: 8] = 8'hFF;
    end
    return k & m;
  endfunction

  // one byte of msb-first crc32
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      if (c[31]) c = {c[30:0], 1'b0} ^ CRC_POLY;
      else c = {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/chtc_if.sv
// request and result channel interfaces, valid/ready handshake
// depends on chtc_pkg

interface chtc_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [chtc_pkg::KEY_W-1:0]    key_in;
  logic [chtc_pkg::IDX_IN_W-1:0] entry_index;
  logic                          reclaim;

  modport source (output valid, output command, output key_in, output entry_index,
                  output reclaim, input ready);
  modport sink (input valid, input command, input key_in, input entry_index,
                input reclaim, output ready);
endinterface

interface chtc_out_if;
  logic                          valid;
  logic                          ready;
  logic [chtc_pkg::STAT_W-1:0]   status;
  logic [chtc_pkg::IDX_IN_W-1:0] entry_id;
  logic [chtc_pkg::KEY_W-1:0]    key_out;

  modport source (output valid, output status, output entry_id, output key_out,
                  input ready);
  modport sink (input valid, input status, input entry_id, input key_out,
                output ready);
endinterface

FILE: rtl/core/chained_hash_table_crc32.sv
// find/insert walk the bucket chain after hashing, remove rehashes the stored key and unlinks it
// from the chain head or further down; a stalled result holds the back part until taken
// throughput: one request at a time in each part, front hashes the next key while back walks
// reset: synchronous active low, then buckets cleared one a cycle, all NUM_BUCKETS of them

module chained_hash_table_crc32 #(
  parameter int NUM_BUCKETS = 2039,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [chtc_pkg::KB_W-1:0] cfg_wdata,
  chtc_in_if.sink                   in_ch,
  chtc_out_if.source                out_ch
);
  import chtc_pkg::*;

  localparam int Q_DEPTH = 2;

  logic [KB_W-1:0] key_bytes_r;
  logic [KB_W-1:0] eff;
  logic            clearing;
  logic            q_push, q_pop, q_full, q_empty;
  q_item_t         q_wdata, q_rdata;
  logic [$bits(q_item_t)-1:0] q_rbits;

  // key length register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) key_bytes_r <= KB_RESET;
    else if (cfg_we) key_bytes_r <= cfg_wdata;
  end

  // out of range lengths folded to one or eight bytes
  assign eff = eff_len(key_bytes_r);

  // front: takes requests, hashes keys of find and insert requests
  chtc_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .eff_len (eff),
    .hold    (clearing),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // decouples hashing from chain walks
  chtc_queue #(.WIDTH($bits(q_item_t)), .DEPTH(Q_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rbits),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_rdata = q_item_t'(q_rbits);

  // back: memories, chain walk and unlink, result register
  chtc_back #(.NUM_BUCKETS(NUM_BUCKETS), .MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_len  (eff),
    .q_item   (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

FILE: rtl/core/chtc_ram.sv
// generic single write, single read ram with registered read data
// no dependencies

module chtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/chtc_hash.sv
// bucket hash unit: crc32 one byte a cycle, then remainder by reciprocal multiply, subtract and final correction
// depends on chtc_pkg

module chtc_hash #(
  parameter int NUM_BUCKETS = 2039
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [chtc_pkg::KEY_W-1:0]           key,
  input  logic [chtc_pkg::KB_W-1:0]            nbytes,
  output logic                                 done,
  output logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket
);
  import chtc_pkg::*;

  localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [31:0] NB1   = 32'(NUM_BUCKETS);
  localparam logic [31:0] NB2   = 32'(2 * NUM_BUCKETS);
  localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / NUM_BUCKETS);

  hash_state_t      state_r, state_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      q_r, q_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KB_W-1:0]  cnt_r, cnt_nxt;
  logic [BKT_W-1:0] rem_r, rem_nxt;
  logic             done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    crc_r <= crc_nxt;
    q_r   <= q_nxt;
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
  end

  always_comb begin
    logic [63:0] p;
    logic [31:0] qn;
    logic [31:0] r;
    state_nxt = state_r;
    crc_nxt   = crc_r;
    q_nxt     = q_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    p  = '0;
    qn = '0;
    r  = crc_r;
    unique case (state_r)
      HS_IDLE: begin
        if (start) begin
          crc_nxt   = CRC_INIT;
          key_nxt   = key;
          cnt_nxt   = nbytes;
          state_nxt = HS_CRC;
        end
      end
      HS_CRC: begin
        crc_nxt = crc_byte(crc_r, key_r[7:0]);
        key_nxt = key_r >> 8;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r <= 4'd1) state_nxt = HS_MUL;
      end
      HS_MUL: begin
        // quotient estimate, at most two below the true quotient
        p         = 64'(crc_r) * 64'(RECIP);
        q_nxt     = p[63:32];
        state_nxt = HS_SUB;
      end
      HS_SUB: begin
        qn        = q_r * NB1;
        crc_nxt   = crc_r - qn;
        state_nxt = HS_FIX;
      end
      HS_FIX: begin
        // partial remainder is below three times the bucket count
        if (crc_r >= NB2) r = crc_r - NB2;
        else if (crc_r >= NB1) r = crc_r - NB1;
        rem_nxt   = BKT_W'(r);
        done_nxt  = 1'b1;
        state_nxt = HS_IDLE;
      end
      default: state_nxt = HS_IDLE;
    endcase
  end

  assign done   = done_r;
  assign bucket = rem_r;

endmodule

FILE: rtl/core/chtc_queue.sv
// short register queue between the front and back parts
// no dependencies

module chtc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == LAST) ? '0 : wr_r + 1'b1;
      if (do_pop) rd_r <= (rd_r == LAST) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
    if (do_push) mem_r[wr_r] <= wdata;
  end

endmodule

FILE: rtl/core/chtc_front.sv
// front part: accepts requests, hashes find and insert keys, queues the work
// depends on chtc_pkg, chtc_if, chtc_hash

module chtc_front #(
  parameter int NUM_BUCKETS = 2039
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [chtc_pkg::KB_W-1:0] eff_len,
  input  logic                     hold,
  chtc_in_if.sink                  in_ch,
  input  logic                     q_full,
  output logic                     q_push,
  output chtc_pkg::q_item_t        q_data
);
  import chtc_pkg::*;

  localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  front_state_t     state_r, state_nxt;
  q_item_t          it_r, it_nxt;
  logic             hash_start, hash_done, accept;
  logic [BKT_W-1:0] hash_bucket;

  chtc_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key    (in_ch.key_in),
    .nbytes (eff_len),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FR_IDLE;
    else state_r <= state_nxt;
    it_r <= it_nxt;
  end

  always_comb begin
    q_item_t req;
    req.cmd     = cmd_t'(in_ch.command);
    req.key     = key_mask(in_ch.key_in, eff_len);
    req.idx     = in_ch.entry_index;
    req.reclaim = in_ch.reclaim;
    req.bucket  = '0;
    state_nxt   = state_r;
    it_nxt      = it_r;
    hash_start  = 1'b0;
    q_push      = 1'b0;
    q_data      = req;
    in_ch.ready = 1'b0;
    accept      = 1'b0;
    unique case (state_r)
      FR_IDLE: begin
        in_ch.ready = !hold && !q_full;
        accept = in_ch.valid && in_ch.ready;
        if (accept) begin
          if (req.cmd == CMD_FIND || req.cmd == CMD_INSERT) begin
            hash_start = 1'b1;
            it_nxt     = req;
            state_nxt  = FR_HASH;
          end else begin
            q_push = 1'b1;
          end
        end
      end
      FR_HASH: begin
        if (hash_done) begin
          q_data        = it_r;
          q_data.bucket = BKT_FLD_W'(hash_bucket);
          q_push        = 1'b1;
          state_nxt     = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/chtc_back.sv
// back part: bucket, link and entry memories, chain walks, result register
// depends on chtc_pkg, chtc_if, chtc_ram, chtc_hash

module chtc_back #(
  parameter int NUM_BUCKETS = 2039,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [chtc_pkg::KB_W-1:0] eff_len,
  input  chtc_pkg::q_item_t         q_item,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      clearing,
  chtc_out_if.source                out_ch
);
  import chtc_pkg::*;

  localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int LNK_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (LNK_W > IDX_IN_W) ? LNK_W : IDX_IN_W;
  localparam int ENT_W = KEY_W + 1;
  localparam logic [LNK_W-1:0] NIL = LNK_W'(MAX_ENTRIES);
  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(NUM_BUCKETS - 1);

  back_state_t      state_r, state_nxt;
  q_item_t          item_r, item_nxt;
  logic [LNK_W-1:0] cnt_r, cnt_nxt;
  logic [LNK_W-1:0] v_r, v_nxt;
  logic [LNK_W-1:0] steps_r, steps_nxt;
  logic [LNK_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [BKT_W-1:0] bkt_r, bkt_nxt;
  logic [BKT_W-1:0] clr_r, clr_nxt;
  logic             ov_r, ov_nxt;
  status_t          ost_r, ost_nxt;
  logic [IDX_IN_W-1:0] oid_r, oid_nxt;
  logic [KEY_W-1:0] okey_r, okey_nxt;

  logic             bkt_we, lnk_we, ent_we;
  logic [BKT_W-1:0] bkt_waddr, bkt_raddr;
  logic [LNK_W-1:0] bkt_wdata, bkt_rdata;
  logic [IDX_W-1:0] lnk_waddr, lnk_raddr, ent_waddr, ent_raddr;
  logic [LNK_W-1:0] lnk_wdata, lnk_rdata;
  logic [ENT_W-1:0] ent_wdata, ent_rdata;
  logic             hash_start, hash_done;
  logic [BKT_W-1:0] hash_bucket;

  chtc_ram #(.WIDTH(LNK_W), .DEPTH(NUM_BUCKETS)) u_bkt_ram (
    .clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
    .raddr(bkt_raddr), .rdata(bkt_rdata)
  );

  chtc_ram #(.WIDTH(LNK_W), .DEPTH(MAX_ENTRIES)) u_lnk_ram (
    .clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .raddr(lnk_raddr), .rdata(lnk_rdata)
  );

  // valid bit on top of the stored key
  chtc_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  chtc_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key    (ent_rdata[KEY_W-1:0]),
    .nbytes (eff_len),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    item_r  <= item_nxt;
    v_r     <= v_nxt;
    steps_r <= steps_nxt;
    head_r  <= head_nxt;
    prev_r  <= prev_nxt;
    key_r   <= key_nxt;
    bkt_r   <= bkt_nxt;
    ost_r   <= ost_nxt;
    oid_r   <= oid_nxt;
    okey_r  <= okey_nxt;
  end

  assign clearing        = (state_r == BK_CLEAR);
  assign out_ch.valid    = ov_r;
  assign out_ch.status   = ost_r;
  assign out_ch.entry_id = oid_r;
  assign out_ch.key_out  = okey_r;

  always_comb begin
    logic [CMP_W-1:0] idx_c, cnt_c, hv_c;
    logic [IDX_W-1:0] idx_a;
    logic [LNK_W-1:0] steps_inc;
    logic             result;
    status_t          r_st;
    logic [IDX_IN_W-1:0] r_id;
    logic [KEY_W-1:0] r_key;

    idx_c     = CMP_W'(item_r.idx);
    cnt_c     = CMP_W'(cnt_r);
    hv_c      = CMP_W'(bkt_rdata);
    idx_a     = IDX_W'(item_r.idx);
    steps_inc = steps_r + 1'b1;
    result    = 1'b0;
    r_st      = ST_DONE;
    r_id      = '0;
    r_key     = '0;

    state_nxt = state_r;
    item_nxt  = item_r;
    cnt_nxt   = cnt_r;
    v_nxt     = v_r;
    steps_nxt = steps_r;
    head_nxt  = head_r;
    prev_nxt  = prev_r;
    key_nxt   = key_r;
    bkt_nxt   = bkt_r;
    clr_nxt   = clr_r;
    q_pop     = 1'b0;
    hash_start = 1'b0;

    bkt_we = 1'b0; bkt_waddr = bkt_r; bkt_wdata = NIL; bkt_raddr = bkt_r;
    lnk_we = 1'b0; lnk_waddr = idx_a; lnk_wdata = NIL; lnk_raddr = idx_a;
    ent_we = 1'b0; ent_waddr = idx_a; ent_wdata = '0;  ent_raddr = idx_a;

    unique case (state_r)
      BK_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_BKT) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (!ov_r && !q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          if (q_item.cmd == CMD_FIND || q_item.cmd == CMD_INSERT) state_nxt = BK_HEAD_RD;
          else state_nxt = BK_ID_RD;
        end
      end
      BK_HEAD_RD: begin
        bkt_raddr = BKT_W'(item_r.bucket);
        bkt_nxt   = BKT_W'(item_r.bucket);
        state_nxt = BK_HEAD_CHK;
      end
      BK_HEAD_CHK: begin
        head_nxt  = bkt_rdata;
        v_nxt     = bkt_rdata;
        steps_nxt = '0;
        ent_raddr = IDX_W'(bkt_rdata);
        lnk_raddr = IDX_W'(bkt_rdata);
        if (bkt_rdata < cnt_r) state_nxt = BK_WALK;
        else state_nxt = BK_MISS;
      end
      BK_WALK: begin
        if (ent_rdata[KEY_W] && key_mask(ent_rdata[KEY_W-1:0], eff_len) == item_r.key) begin
          result    = 1'b1;
          r_id      = IDX_IN_W'(v_r);
          state_nxt = BK_IDLE;
        end else if (lnk_rdata < cnt_r && steps_inc < NIL) begin
          ent_raddr = IDX_W'(lnk_rdata);
          lnk_raddr = IDX_W'(lnk_rdata);
          v_nxt     = lnk_rdata;
          steps_nxt = steps_inc;
        end else begin
          state_nxt = BK_MISS;
        end
      end
      BK_MISS: begin
        result    = 1'b1;
        state_nxt = BK_IDLE;
        if (item_r.cmd == CMD_FIND) begin
          r_st = ST_MISS;
        end else if (cnt_r == NIL) begin
          r_st = ST_FULL;
        end else begin
          // new entry goes to the chain head
          r_st      = ST_NEW;
          r_id      = IDX_IN_W'(cnt_r);
          lnk_we    = 1'b1;
          lnk_waddr = IDX_W'(cnt_r);
          lnk_wdata = head_r;
          ent_we    = 1'b1;
          ent_waddr = IDX_W'(cnt_r);
          ent_wdata = {1'b1, item_r.key};
          bkt_we    = 1'b1;
          bkt_waddr = bkt_r;
          bkt_wdata = cnt_r;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      BK_ID_RD: begin
        if (idx_c < cnt_c) begin
          state_nxt = BK_ID_CHK;
        end else begin
          result    = 1'b1;
          r_st      = ST_BADID;
          state_nxt = BK_IDLE;
        end
      end
      BK_ID_CHK: begin
        if (!ent_rdata[KEY_W]) begin
          result    = 1'b1;
          r_st      = ST_BADID;
          state_nxt = BK_IDLE;
        end else if (item_r.cmd == CMD_READ) begin
          result    = 1'b1;
          r_key     = key_mask(ent_rdata[KEY_W-1:0], eff_len);
          state_nxt = BK_IDLE;
        end else begin
          key_nxt    = ent_rdata[KEY_W-1:0];
          hash_start = 1'b1;
          state_nxt  = BK_REM_HASH;
        end
      end
      BK_REM_HASH: begin
        if (hash_done) begin
          bkt_nxt   = hash_bucket;
          bkt_raddr = hash_bucket;
          state_nxt = BK_UNL_HEAD;
        end
      end
      BK_UNL_HEAD: begin
        v_nxt     = bkt_rdata;
        steps_nxt = '0;
        if (hv_c == idx_c) begin
          state_nxt = BK_UNL_HEADFIX;
        end else if (bkt_rdata < cnt_r) begin
          lnk_raddr = IDX_W'(bkt_rdata);
          state_nxt = BK_UNL_WALK;
        end else begin
          state_nxt = BK_REM_FIN;
        end
      end
      BK_UNL_HEADFIX: begin
        bkt_we    = 1'b1;
        bkt_waddr = bkt_r;
        bkt_wdata = lnk_rdata;
        lnk_we    = 1'b1;
        lnk_waddr = idx_a;
        state_nxt = BK_REM_FIN;
      end
      BK_UNL_WALK: begin
        if (CMP_W'(lnk_rdata) == idx_c) begin
          prev_nxt  = IDX_W'(v_r);
          state_nxt = BK_UNL_LINKFIX;
        end else if (lnk_rdata < cnt_r && steps_inc < NIL) begin
          lnk_raddr = IDX_W'(lnk_rdata);
          v_nxt     = lnk_rdata;
          steps_nxt = steps_inc;
        end else begin
          state_nxt = BK_REM_FIN;
        end
      end
      BK_UNL_LINKFIX: begin
        lnk_we    = 1'b1;
        lnk_waddr = prev_r;
        lnk_wdata = lnk_rdata;
        state_nxt = BK_UNL_LINKNIL;
      end
      BK_UNL_LINKNIL: begin
        lnk_we    = 1'b1;
        lnk_waddr = idx_a;
        state_nxt = BK_REM_FIN;
      end
      BK_REM_FIN: begin
        ent_we    = 1'b1;
        ent_waddr = idx_a;
        ent_wdata = {1'b0, key_r};
        if (item_r.reclaim && (idx_c + 1'b1) == cnt_c) cnt_nxt = cnt_r - 1'b1;
        result    = 1'b1;
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase

    ov_nxt   = ov_r && !out_ch.ready;
    ost_nxt  = ost_r;
    oid_nxt  = oid_r;
    okey_nxt = okey_r;
    if (result) begin
      ov_nxt   = 1'b1;
      ost_nxt  = r_st;
      oid_nxt  = r_id;
      okey_nxt = r_key;
    end
  end

endmodule

FILE: rtl/core/chtc_checker.sv
// port level checks on the result channel of the hash table
// depends on chtc_pkg, bound to chained_hash_table_crc32

module chtc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [chtc_pkg::STAT_W-1:0]   out_status,
  input logic [chtc_pkg::IDX_IN_W-1:0] out_entry_id,
  input logic [chtc_pkg::KEY_W-1:0]    out_key_out
);
  import chtc_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_BADID)
    else $error("status code out of range");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MISS || out_status == ST_FULL || out_status == ST_BADID)
      |-> out_entry_id == '0)
    else $error("entry id set on failed request");

  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_key_out == '0)
    else $error("key returned on non read result");

endmodule

bind chained_hash_table_crc32 chtc_checker u_chtc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_entry_id (out_ch.entry_id),
  .out_key_out  (out_ch.key_out)
);

FILE: tb/tb_chained_hash_table_crc32.sv
// testbench for the chained crc32 hash table: random and directed requests checked
// against a behavioral table model. depends on chtc_pkg, chtc_if and the rtl top level
`timescale 1ns / 100ps

module tb_chained_hash_table_crc32;
  import chtc_pkg::*;

  localparam int NBKT = 2039;
  localparam int NENT = 4096;
  localparam int NIL_ID = NENT;
  localparam int WATCHDOG_MAX = 20000;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] key;
    logic [11:0] idx;
    logic        reclaim;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] id;
    logic [63:0] key;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [KB_W-1:0] cfg_wdata = '0;

  chtc_in_if  req_ch ();
  chtc_out_if rsp_ch ();

  chained_hash_table_crc32 DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(req_ch.sink), .out_ch(rsp_ch.source)
  );

  always #1 clk = ~clk;

  // table model state
  int unsigned mdl_key_bytes;
  int unsigned mdl_head [NBKT];
  int unsigned mdl_next [NENT];
  logic [63:0] mdl_key [NENT];
  bit          mdl_valid [NENT];
  int unsigned mdl_count;

  req_t req_q[$];
  rsp_t rsp_q[$];
  int   errors = 0;
  int   n_acc = 0;
  int   n_chk = 0;
  bit   quiet = 1'b0;    // no idling in the last part of the run
  int   watchdog = 0;
  logic [63:0] key_pool[$];

  function automatic int unsigned key_len();
    if (mdl_key_bytes == 0) return 1;
    if (mdl_key_bytes > 8) return 8;
    return mdl_key_bytes;
  endfunction

  function automatic logic [63:0] trim_key(logic [63:0] k);
    int unsigned n;
    n = key_len();
    for (int i = 0; i < 8; i++) if (i >= n) k[8*i +: 8] = 8'h00;
    return k;
  endfunction

  function automatic int unsigned bucket_index(logic [63:0] k);
    logic [31:0] crc;
    logic [7:0]  b;
    int unsigned n;
    crc = 32'hFFFF_FFFF;
    n = key_len();
    for (int i = 0; i < n; i++) begin
      b = k[8*i +: 8];
      crc = crc ^ {b, 24'h0};
      for (int j = 0; j < 8; j++) crc = crc[31] ? ({crc[30:0], 1'b0} ^ 32'h04C1_1DB7)
                                                : {crc[30:0], 1'b0};
    end
    return crc % NBKT;
  endfunction

  function automatic int unsigned chain_search(logic [63:0] k, int unsigned bkt);
    int unsigned v, steps;
    logic [63:0] mk;
    v = mdl_head[bkt];
    steps = 0;
    mk = trim_key(k);
    while (v < mdl_count && v < NIL_ID && steps < NENT) begin
      if (mdl_valid[v] && trim_key(mdl_key[v]) == mk) return v;
      v = mdl_next[v];
      steps++;
    end
    return NIL_ID;
  endfunction

  function automatic void chain_unlink(int unsigned id);
    int unsigned h, v, steps;
    h = bucket_index(mdl_key[id]);
    v = mdl_head[h];
    steps = 0;
    if (v == id) begin
      mdl_head[h] = mdl_next[id];
      mdl_next[id] = NIL_ID;
      return;
    end
    while (v < mdl_count && v < NIL_ID && steps < NENT) begin
      if (mdl_next[v] == id) begin
        mdl_next[v] = mdl_next[id];
        mdl_next[id] = NIL_ID;
        return;
      end
      v = mdl_next[v];
      steps++;
    end
  endfunction

  // apply one request to the model and return the response it should produce
  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    int unsigned h, v;
    o = '{status: ST_DONE, id: '0, key: '0};
    if (r.cmd == CMD_FIND || r.cmd == CMD_INSERT) begin
      h = bucket_index(r.key);
      v = chain_search(r.key, h);
      if (v != NIL_ID) o.id = v[11:0];
      else if (r.cmd == CMD_FIND) o.status = ST_MISS;
      else if (mdl_count >= NENT) o.status = ST_FULL;
      else begin
        o.id = mdl_count[11:0];
        mdl_next[mdl_count] = mdl_head[h];
        mdl_key[mdl_count] = trim_key(r.key);
        mdl_valid[mdl_count] = 1'b1;
        mdl_head[h] = mdl_count;
        mdl_count++;
        o.status = ST_NEW;
      end
    end else if (r.idx < mdl_count && mdl_valid[r.idx]) begin
      if (r.cmd == CMD_REMOVE) begin
        chain_unlink(r.idx);
        mdl_valid[r.idx] = 1'b0;
        if (r.reclaim && r.idx + 1 == mdl_count) mdl_count--;
      end else o.key = trim_key(mdl_key[r.idx]);
    end else o.status = ST_BADID;
    return o;
  endfunction

  // request driver
  int req_gap = 0;
  always @(posedge clk) begin
    if (req_ch.valid && req_ch.ready) begin
      rsp_q.push_back(table_apply(req_q.pop_front()));
      n_acc++;
    end
    if (req_ch.valid && !req_ch.ready) begin
      // hold the current request
    end else if (req_gap > 0) begin
      req_gap <= req_gap - 1;
      req_ch.valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      req_gap <= $urandom_range(1, 16);
      req_ch.valid <= 1'b0;
    end else if (req_q.size() > 0) begin
      req_ch.valid       <= 1'b1;
      req_ch.command     <= req_q[0].cmd;
      req_ch.key_in      <= req_q[0].key;
      req_ch.entry_index <= req_q[0].idx;
      req_ch.reclaim     <= req_q[0].reclaim;
    end else req_ch.valid <= 1'b0;
  end

  // response monitor, with random backpressure
  int rsp_stall = 0;
  always @(posedge clk) begin
    rsp_t exp_r;
    if (rsp_ch.valid && rsp_ch.ready) begin
      n_chk++;
      if (rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response status %0d id %0d key %h", $time,
                 rsp_ch.status, rsp_ch.entry_id, rsp_ch.key_out);
      end else begin
        exp_r = rsp_q.pop_front();
        if (rsp_ch.status !== exp_r.status || rsp_ch.entry_id !== exp_r.id ||
            rsp_ch.key_out !== exp_r.key) begin
          errors++;
          $display("%0t: mismatch expected status %0d id %0d key %h, got %0d %0d %h",
                   $time, exp_r.status, exp_r.id, exp_r.key, rsp_ch.status,
                   rsp_ch.entry_id, rsp_ch.key_out);
        end
      end
    end
    if (rsp_stall > 0) begin
      rsp_stall <= rsp_stall - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      rsp_stall <= $urandom_range(1, 16);
      rsp_ch.ready <= 1'b0;
    end else rsp_ch.ready <= 1'b1;
  end

  // watchdog on cycles with no handshake while requests or responses are pending
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (req_q.size() == 0 && rsp_q.size() == 0)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_MAX) begin
      $display("%0t: timeout, %0d requests pending, %0d responses due", $time,
               req_q.size(), rsp_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // draw a key: mostly reuse a known key so finds and duplicate inserts hit
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    if (key_pool.size() > 0 && $urandom_range(0, 2) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    k = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) k = k & 64'h0000_0000_0000_00FF;
    key_pool.push_back(k);
    return k;
  endfunction

  function automatic int unsigned pick_idx();
    int unsigned hi;
    hi = key_pool.size() + 4;
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, hi > 4095 ? 4095 : hi);
  endfunction

  task automatic push_req(cmd_t c, logic [63:0] k, logic [11:0] i, logic rc);
    req_t r;
    r.cmd = c; r.key = k; r.idx = i; r.reclaim = rc;
    req_q.push_back(r);
  endtask

  // wait until the table is idle, then change the key length
  task automatic set_key_bytes(int unsigned kb);
    wait (req_q.size() == 0 && rsp_q.size() == 0);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= kb[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_key_bytes = kb;
    key_pool.delete();
  endtask

  task automatic random_phase(int n);
    int unsigned sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) push_req(CMD_INSERT, pick_key(), 12'($urandom), 1'($urandom));
      else if (sel < 65) push_req(CMD_FIND, pick_key(), 12'($urandom), 1'($urandom));
      else if (sel < 85) push_req(CMD_REMOVE, 64'($urandom), 12'(pick_idx()), 1'($urandom));
      else push_req(CMD_READ, 64'($urandom), 12'(pick_idx()), 1'($urandom));
    end
  endtask

  initial begin
    int unsigned kbs[6];
    req_ch.valid = 1'b0;
    req_ch.command = CMD_FIND;
    req_ch.key_in = '0;
    req_ch.entry_index = '0;
    req_ch.reclaim = 1'b0;
    rsp_ch.ready = 1'b0;
    mdl_key_bytes = 8;
    for (int i = 0; i < NBKT; i++) mdl_head[i] = NIL_ID;
    for (int i = 0; i < NENT; i++) begin
      mdl_next[i] = 0; mdl_key[i] = '0; mdl_valid[i] = 1'b0;
    end
    mdl_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, duplicates, bad ids, reclaim
    push_req(CMD_FIND, '0, '0, 1'b0);
    push_req(CMD_READ, '0, '0, 1'b0);
    push_req(CMD_REMOVE, '0, 12'hFFF, 1'b1);
    push_req(CMD_INSERT, '0, '0, 1'b0);
    push_req(CMD_INSERT, '1, 12'hFFF, 1'b1);
    push_req(CMD_INSERT, '1, '0, 1'b0);
    push_req(CMD_FIND, '1, '0, 1'b0);
    push_req(CMD_READ, '0, 12'd1, 1'b0);
    push_req(CMD_INSERT, 64'h0123_4567_89AB_CDEF, '0, 1'b0);
    push_req(CMD_REMOVE, '0, 12'd1, 1'b0);
    push_req(CMD_REMOVE, '0, 12'd1, 1'b0);
    push_req(CMD_READ, '0, 12'd1, 1'b0);
    push_req(CMD_FIND, '1, '0, 1'b0);
    push_req(CMD_REMOVE, '0, 12'd2, 1'b1);
    push_req(CMD_INSERT, 64'hA5A5_A5A5_A5A5_A5A5, '0, 1'b0);
    push_req(CMD_READ, '0, 12'd2, 1'b0);
    push_req(CMD_READ, '0, 12'd4095, 1'b0);

    // short keys first while the table is small, then the extremes and out of range
    kbs = '{1, 0, 3, 8, 15, 5};
    set_key_bytes(kbs[0]);
    random_phase(300);
    // removes after a length change exercise the not-in-chain path
    push_req(CMD_REMOVE, '0, 12'd0, 1'b0);
    push_req(CMD_REMOVE, '0, 12'd1, 1'b0);
    for (int p = 1; p < 6; p++) begin
      set_key_bytes(kbs[p]);
      if (p == 5) quiet = 1'b1;
      random_phase(300);
    end

    // ids at the top of the range on a partly filled table
    push_req(CMD_INSERT, {$urandom, $urandom}, '0, 1'b0);
    push_req(CMD_REMOVE, '0, 12'd4095, 1'b1);
    push_req(CMD_INSERT, {$urandom, $urandom}, '0, 1'b0);
    push_req(CMD_READ, '0, 12'd4095, 1'b0);

    wait (req_q.size() == 0 && rsp_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d requests and %0d responses over six key lengths", n_acc, n_chk);
    $display("table ended with %0d entries, idle bursts on both channels", mdl_count);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
